>>> hdl/urc_pkg.sv
package urc_pkg;

    localparam int IP_HEADER_BYTES = 20;
    localparam int UDP_HEADER_BYTES = 8;
    localparam int ADDR_BYTES = 8;

    localparam int POS_W = 17;
    localparam int SUM_W = 32;
    localparam int CNT_W = POS_W + 1;

    localparam logic [POS_W-1:0] POS_MAX = '1;
    localparam logic [POS_W-1:0] ADDR_START = POS_W'(IP_HEADER_BYTES - ADDR_BYTES);
    localparam logic [POS_W-1:0] HDR_START = POS_W'(IP_HEADER_BYTES);
    localparam logic [POS_W-1:0] HDR_END = POS_W'(IP_HEADER_BYTES + UDP_HEADER_BYTES);

    localparam logic [15:0] UDP_PROTOCOL = 16'd17;

    // Queue between front and back; depth must be a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] CFG_ECHO_PORT = 2'd0;
    localparam logic [1:0] CFG_DISCARD_PORT = 2'd1;
    localparam logic [1:0] CFG_HANDLER_PRESENT = 2'd2;

    typedef enum logic [2:0] {
        VERDICT_DELIVER = 3'd0,
        VERDICT_ECHO = 3'd1,
        VERDICT_DISCARD = 3'd2,
        VERDICT_CSUM_ERR = 3'd3,
        VERDICT_NO_HANDLER = 3'd4,
        VERDICT_SHORT = 3'd5
    } verdict_t;

    // One finished datagram, handed from front to back.
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] length;
        logic [15:0] rx_csum;
        logic is_short;
    } urc_rec_t;

    typedef struct packed {
        logic [15:0] echo_port;
        logic [15:0] discard_port;
        logic handler_present;
    } urc_cfg_t;

endpackage

>>> hdl/urc_front.sv
module urc_front import urc_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic s_last_byte,
    input  logic q_full,
    output logic q_push,
    output urc_rec_t q_rec
);

    localparam logic [1:0] FLD_SRC = 2'd0;
    localparam logic [1:0] FLD_DST = 2'd1;
    localparam logic [1:0] FLD_LEN = 2'd2;
    localparam logic [1:0] FLD_CSUM = 2'd3;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [SUM_W-1:0] acc_reg, acc_next;
    logic [7:0] hold_reg, hold_next;
    logic [15:0] src_reg, src_next;
    logic [15:0] dst_reg, dst_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] csum_reg, csum_next;

    logic accept;
    logic [SUM_W-1:0] weighted;
    logic [POS_W-1:0] off;
    logic [POS_W-1:0] limit;
    logic [POS_W-1:0] limit_next;
    logic [CNT_W-1:0] count;
    logic [15:0] word;

    assign s_ready = ~q_full;
    assign accept = s_valid & s_ready;

    always_comb begin
        acc_next = acc_reg;
        hold_next = hold_reg;
        src_next = src_reg;
        dst_next = dst_reg;
        len_next = len_reg;
        csum_next = csum_reg;

        // odd positions are the low byte of a 16-bit word
        weighted = pos_reg[0] ? {24'd0, s_rx_byte} : {16'd0, s_rx_byte, 8'd0};
        off = pos_reg - HDR_START;
        limit = HDR_START + {1'b0, len_reg};
        word = {hold_reg, s_rx_byte};

        if (pos_reg >= ADDR_START && pos_reg < HDR_START) begin
            acc_next = acc_reg + weighted;
        end else if (pos_reg >= HDR_START && pos_reg < HDR_END) begin
            if (!off[0]) begin
                hold_next = s_rx_byte;
            end else begin
                unique case (off[2:1])
                    FLD_SRC:  src_next = word;
                    FLD_DST:  dst_next = word;
                    FLD_LEN:  len_next = word;
                    FLD_CSUM: csum_next = word;
                    default:  csum_next = csum_reg;
                endcase
            end
        end else if (pos_reg >= HDR_END && pos_reg < limit) begin
            acc_next = acc_reg + weighted;
        end

        pos_next = (pos_reg != POS_MAX) ? pos_reg + 1'b1 : pos_reg;

        limit_next = HDR_START + {1'b0, len_next};
        count = {1'b0, pos_reg} + 1'b1;

        q_rec.sum = acc_next;
        q_rec.sport = src_next;
        q_rec.dport = dst_next;
        q_rec.length = len_next;
        q_rec.rx_csum = csum_next;
        q_rec.is_short = (count < {1'b0, HDR_END}) || (count < {1'b0, limit_next});
    end

    assign q_push = accept & s_last_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            acc_reg <= '0;
            hold_reg <= '0;
            src_reg <= '0;
            dst_reg <= '0;
            len_reg <= '0;
            csum_reg <= '0;
        end else if (accept) begin
            if (s_last_byte) begin
                // datagram done: clear for the next one
                pos_reg <= '0;
                acc_reg <= '0;
                hold_reg <= '0;
                src_reg <= '0;
                dst_reg <= '0;
                len_reg <= '0;
                csum_reg <= '0;
            end else begin
                pos_reg <= pos_next;
                acc_reg <= acc_next;
                hold_reg <= hold_next;
                src_reg <= src_next;
                dst_reg <= dst_next;
                len_reg <= len_next;
                csum_reg <= csum_next;
            end
        end
    end

endmodule

>>> hdl/urc_fifo.sv
module urc_fifo import urc_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  urc_rec_t push_rec,
    input  logic pop,
    output urc_rec_t pop_rec,
    output logic full,
    output logic empty
);

    urc_rec_t mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0] cnt_reg;

    assign full = (cnt_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign pop_rec = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

>>> hdl/urc_back.sv
module urc_back import urc_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  urc_cfg_t cfg,
    input  logic q_empty,
    input  urc_rec_t q_rec,
    output logic q_pop,
    output logic m_valid,
    input  logic m_ready,
    output logic [2:0] m_verdict,
    output logic [15:0] m_source_port,
    output logic [15:0] m_dest_port,
    output logic [15:0] m_udp_length
);

    logic s1_valid_reg;
    logic [SUM_W-1:0] s1_sum_reg;
    urc_rec_t s1_rec_reg;

    logic m_valid_reg;
    verdict_t verdict_reg, verdict_next;
    logic [15:0] src_reg, dst_reg, len_reg;

    logic out_load;
    logic s1_load;
    logic [SUM_W-1:0] hdr_terms;
    logic [SUM_W-1:0] sum_next;
    logic [16:0] fold1;
    logic [15:0] fold2;
    logic [15:0] csum;

    assign out_load = ~m_valid_reg | m_ready;
    assign s1_load = ~s1_valid_reg | out_load;
    assign q_pop = s1_load & ~q_empty;

    // UDP header bytes count only below the UDP length
    always_comb begin
        hdr_terms = '0;
        if (q_rec.length > 16'd0) hdr_terms = hdr_terms + {16'd0, q_rec.sport[15:8], 8'd0};
        if (q_rec.length > 16'd1) hdr_terms = hdr_terms + {24'd0, q_rec.sport[7:0]};
        if (q_rec.length > 16'd2) hdr_terms = hdr_terms + {16'd0, q_rec.dport[15:8], 8'd0};
        if (q_rec.length > 16'd3) hdr_terms = hdr_terms + {24'd0, q_rec.dport[7:0]};
        if (q_rec.length > 16'd4) hdr_terms = hdr_terms + {16'd0, q_rec.length[15:8], 8'd0};
        if (q_rec.length > 16'd5) hdr_terms = hdr_terms + {24'd0, q_rec.length[7:0]};
        sum_next = q_rec.sum + {16'd0, UDP_PROTOCOL} + {16'd0, q_rec.length} + hdr_terms;
    end

    always_comb begin
        fold1 = {1'b0, s1_sum_reg[31:16]} + {1'b0, s1_sum_reg[15:0]};
        fold2 = fold1[15:0] + {15'd0, fold1[16]};
        csum = ~fold2;
        if (csum == 16'd0) begin
            csum = 16'hffff;
        end

        priority if (s1_rec_reg.is_short) begin
            verdict_next = VERDICT_SHORT;
        end else if (s1_rec_reg.rx_csum != 16'd0 && s1_rec_reg.rx_csum != csum) begin
            verdict_next = VERDICT_CSUM_ERR;
        end else if (s1_rec_reg.dport == cfg.echo_port) begin
            verdict_next = VERDICT_ECHO;
        end else if (s1_rec_reg.dport == cfg.discard_port) begin
            verdict_next = VERDICT_DISCARD;
        end else if (cfg.handler_present) begin
            verdict_next = VERDICT_DELIVER;
        end else begin
            verdict_next = VERDICT_NO_HANDLER;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_load && !q_empty) begin
            s1_sum_reg <= sum_next;
            s1_rec_reg <= q_rec;
        end
        if (out_load && s1_valid_reg) begin
            verdict_reg <= verdict_next;
            src_reg <= s1_rec_reg.sport;
            dst_reg <= s1_rec_reg.dport;
            len_reg <= s1_rec_reg.length;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s1_load) begin
                s1_valid_reg <= ~q_empty;
            end
            if (out_load) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_verdict = verdict_reg;
    assign m_source_port = src_reg;
    assign m_dest_port = dst_reg;
    assign m_udp_length = len_reg;

endmodule

>>> hdl/udp_receive_checker_unit.sv
// A verdict reaches m_valid through the queue, stage s1 and the output register.
// Throughput: one byte per cycle; the front stalls only when its 2-entry datagram
//   queue is full; the 2-stage pipeline drains one per cycle while m_ready is high.
// Reset (aresetn low, synchronous): clears byte position, sum and header fields,
//   empties the queue and pipeline, and sets echo_port 7, discard_port 9,
//   handler_present 1.
module udp_receive_checker_unit import urc_pkg::*; (
    input  logic aclk,
    input  logic aresetn,

    input  logic s_valid,
    output logic s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic s_last_byte,

    output logic m_valid,
    input  logic m_ready,
    output logic [2:0] m_verdict,
    output logic [15:0] m_source_port,
    output logic [15:0] m_dest_port,
    output logic [15:0] m_udp_length,

    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [15:0] cfg_data
);

    // Configuration registers; writes to unused indexes are dropped.
    urc_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.echo_port <= 16'd7;
            cfg_reg.discard_port <= 16'd9;
            cfg_reg.handler_present <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_ECHO_PORT:       cfg_reg.echo_port <= cfg_data;
                CFG_DISCARD_PORT:    cfg_reg.discard_port <= cfg_data;
                CFG_HANDLER_PRESENT: cfg_reg.handler_present <= cfg_data[0];
                default:             cfg_reg.handler_present <= cfg_reg.handler_present;
            endcase
        end
    end

    // Front: parse header bytes and accumulate the sum, one transfer per cycle unless
    // the queue is full. On the last byte, push a finished record into the queue.
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    urc_rec_t front_rec;
    urc_rec_t back_rec;

    urc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_byte   (s_rx_byte),
        .s_last_byte (s_last_byte),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_rec       (front_rec)
    );

    // Queue: decouples byte intake from verdict delivery.
    urc_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_rec (front_rec),
        .pop      (q_pop),
        .pop_rec  (back_rec),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Back: add pseudo-header terms, fold to 16 bits, then decide the verdict
    // into the output register.
    urc_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .q_empty       (q_empty),
        .q_rec         (back_rec),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_verdict     (m_verdict),
        .m_source_port (m_source_port),
        .m_dest_port   (m_dest_port),
        .m_udp_length  (m_udp_length)
    );

    // The front must never push into a full queue.
    assert property (@(posedge aclk) disable iff (!aresetn) q_push |-> !q_full)
        else $error("queue overflow");

    // The back must never pop an empty queue.
    assert property (@(posedge aclk) disable iff (!aresetn) q_pop |-> !q_empty)
        else $error("queue underflow");

    // A valid result always carries a defined verdict code.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_verdict <= VERDICT_SHORT))
        else $error("verdict code out of range");

    // Reset empties the output stage.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule
